@@ rtl/core/bffl_pkg.sv @@
// Shared types and constants of the best-fit free-list allocator.
package bffl_pkg;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  localparam logic [2:0] ST_REUSED = 3'd0;
  localparam logic [2:0] ST_TOP    = 3'd1;
  localparam logic [2:0] ST_NOMEM  = 3'd2;
  localparam logic [2:0] ST_FREED  = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  // Header bytes in front of each payload
  localparam logic [15:0] HDR_BYTES = 16'd8;
  // Highest top offset that still leaves a 16-bit payload address
  localparam logic [16:0] TOP_LAST  = 17'd65527;
  // Header slots reachable from a 16-bit address
  localparam int SLOT_MAX = 8192;
  // Largest limit that the 17-bit register can express
  localparam int LIM_REG_MAX = 131071;

  // Input word
  typedef struct packed {
    logic        cmd;
    logic [16:0] request_size;
    logic [15:0] block_addr;
  } bffl_req_t;

  // Output word
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] result_addr;
  } bffl_rsp_t;

  // One free-table entry
  typedef struct packed {
    logic [15:0] addr;
    logic [16:0] size;
  } bffl_entry_t;

  localparam int ENTRY_W = 33;

  // Control of the best-fit compare unit
  typedef struct packed {
    logic clr;
    logic vld;
  } bffl_best_ctl_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_END,
    S_PICK,
    S_SHIFT,
    S_TOP,
    S_HDR_RD,
    S_PUSH,
    S_DONE
  } bffl_state_e;

endpackage

@@ rtl/core/best_fit_free_list_allocator_core.sv @@
// Top level of the best-fit free-list heap allocator.
//
// Usage: requests arrive on the in_* channel (valid/ready), one word per
// command: allocate (rounded size plus 8-byte header) or free (payload
// address). Each request gives one word on the out_* channel (valid/ready)
// with a status code and the granted payload address.
// An allocate scans the free table newest first, one entry per
// cycle through the shared compare unit, then, if an entry fits, compacts
// the table behind the chosen entry one entry per cycle.
// The sequencer works through the single free-table memory port with one
// request in work at a time; in_ready_o is high only when idle.
// The result sits in an output register, so a new request is taken while a
// finished word still waits; a stalled receiver holds the sequencer only
// when the next result is ready and the output register is still full.
// Reset: heap_bytes returns to 65536, top to offset 8, free table empty.
// No clearing pass runs; headers are undefined until written.
// A cfg_we_i write sets heap_bytes and also resets top and the free table;
// write it only while the block is idle.
module best_fit_free_list_allocator_core #(
  parameter int MAX_FREE   = 16,
  parameter int HEAP_BYTES = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bffl_pkg::bffl_req_t in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bffl_pkg::bffl_rsp_t out_data_o,
  input  logic                cfg_we_i,
  input  logic [16:0]         cfg_data_i
);

  localparam int IW        = $clog2(MAX_FREE);
  localparam int CW        = $clog2(MAX_FREE + 1);
  localparam int HDR_DEPTH = (HEAP_BYTES / 8 > bffl_pkg::SLOT_MAX) ?
                             bffl_pkg::SLOT_MAX : HEAP_BYTES / 8;
  localparam int HAW       = $clog2(HDR_DEPTH);
  localparam int LIM_MAX   = (HEAP_BYTES > bffl_pkg::LIM_REG_MAX) ?
                             bffl_pkg::LIM_REG_MAX : HEAP_BYTES;
  localparam logic [16:0] LIM_MAX_V = 17'(LIM_MAX);
  localparam logic [13:0] HDR_DEPTH_V = 14'(HDR_DEPTH);
  localparam logic [CW-1:0] MAX_FREE_V = CW'(MAX_FREE);

  bffl_pkg::bffl_state_e state_q, state_d;

  // Control registers
  logic [16:0]   heap_q;
  logic [16:0]   top_q;
  logic [CW-1:0] count_q;
  logic          pend_q;
  logic          out_valid_q;

  // Payload registers
  bffl_pkg::bffl_req_t req_q;
  logic [17:0]         need_q;
  logic [IW-1:0]       scan_idx_q;
  logic [CW-1:0]       sh_idx_q;
  logic [IW-1:0]       pend_idx_q;
  bffl_pkg::bffl_rsp_t res_q;
  bffl_pkg::bffl_rsp_t out_data_q;

  // Datapath nets
  logic                  accept;
  logic                  out_free;
  logic [17:0]           rnd;
  logic [17:0]           need_in;
  logic [16:0]           lim;
  logic                  top_fail;
  logic [15:0]           ru_diff;
  logic                  ru_ok;
  logic [15:0]           fr_diff;
  logic                  fr_ok;
  logic                  sh_issue;
  logic                  count_full;
  logic [CW-1:0]         cnt_m1;
  logic [CW-1:0]         best_idx_p1;

  // Memory ports
  logic                  fl_we;
  logic [IW-1:0]         fl_waddr;
  logic [IW-1:0]         fl_raddr;
  bffl_pkg::bffl_entry_t fl_wdata;
  logic [bffl_pkg::ENTRY_W-1:0] fl_rdata;
  bffl_pkg::bffl_entry_t fl_rd_ent;
  logic                  hd_we;
  logic [HAW-1:0]        hd_waddr;
  logic [16:0]           hd_wdata;
  logic [HAW-1:0]        hd_raddr;
  logic [16:0]           hd_rdata;

  // Compare unit
  bffl_pkg::bffl_best_ctl_t best_ctl;
  logic                     best_found;
  logic [IW-1:0]            best_idx;
  bffl_pkg::bffl_entry_t    best_ent;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Block size: round up to 8, add header
  assign rnd     = {1'b0, in_data_i.request_size} + 18'd7;
  assign need_in = {rnd[17:3] + 15'd1, 3'b000};

  // Top allocation check
  assign lim      = (heap_q > LIM_MAX_V) ? LIM_MAX_V : heap_q;
  assign top_fail = (need_q > {1'b0, lim}) || ((lim - need_q[16:0]) < top_q) ||
                    (top_q > bffl_pkg::TOP_LAST);

  // Header slot of a reused block (address wraps below 8)
  assign ru_diff = best_ent.addr - bffl_pkg::HDR_BYTES;
  assign ru_ok   = {1'b0, ru_diff[15:3]} < HDR_DEPTH_V;

  // Header slot of a freed block
  assign fr_diff = req_q.block_addr - bffl_pkg::HDR_BYTES;
  assign fr_ok   = (req_q.block_addr >= bffl_pkg::HDR_BYTES) &&
                   ({1'b0, fr_diff[15:3]} < HDR_DEPTH_V);

  assign sh_issue    = sh_idx_q < count_q;
  assign count_full  = count_q == MAX_FREE_V;
  assign cnt_m1      = count_q - CW'(1);
  assign best_idx_p1 = CW'(best_idx) + CW'(1);
  assign fl_rd_ent   = bffl_pkg::bffl_entry_t'(fl_rdata);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bffl_pkg::S_IDLE: begin
        if (accept) begin
          if (in_data_i.cmd == bffl_pkg::CMD_ALLOC) begin
            state_d = (count_q == '0) ? bffl_pkg::S_TOP : bffl_pkg::S_SCAN;
          end else begin
            state_d = count_full ? bffl_pkg::S_DONE : bffl_pkg::S_HDR_RD;
          end
        end
      end
      bffl_pkg::S_SCAN: begin
        if (scan_idx_q == '0) begin
          state_d = bffl_pkg::S_SCAN_END;
        end
      end
      bffl_pkg::S_SCAN_END: state_d = bffl_pkg::S_PICK;
      bffl_pkg::S_PICK: begin
        state_d = best_found ? bffl_pkg::S_SHIFT : bffl_pkg::S_TOP;
      end
      bffl_pkg::S_SHIFT: begin
        if (!sh_issue && !pend_q) begin
          state_d = bffl_pkg::S_DONE;
        end
      end
      bffl_pkg::S_TOP:    state_d = bffl_pkg::S_DONE;
      bffl_pkg::S_HDR_RD: state_d = bffl_pkg::S_PUSH;
      bffl_pkg::S_PUSH:   state_d = bffl_pkg::S_DONE;
      bffl_pkg::S_DONE: begin
        if (out_free) begin
          state_d = bffl_pkg::S_IDLE;
        end
      end
      default: state_d = bffl_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: memory ports and compare-unit control
  always_comb begin
    in_ready_o   = 1'b0;
    fl_raddr     = scan_idx_q;
    fl_we        = 1'b0;
    fl_waddr     = pend_idx_q - IW'(1);
    fl_wdata     = fl_rd_ent;
    hd_we        = 1'b0;
    hd_waddr     = ru_diff[HAW+2:3];
    hd_wdata     = need_q[16:0];
    hd_raddr     = fr_diff[HAW+2:3];
    best_ctl.clr = 1'b0;
    best_ctl.vld = 1'b0;
    case (state_q)
      bffl_pkg::S_IDLE: begin
        in_ready_o   = 1'b1;
        best_ctl.clr = 1'b1;
      end
      bffl_pkg::S_SCAN: begin
        best_ctl.vld = pend_q;
      end
      bffl_pkg::S_SCAN_END: begin
        best_ctl.vld = pend_q;
      end
      bffl_pkg::S_PICK: begin
        hd_we = best_found && ru_ok;
      end
      bffl_pkg::S_SHIFT: begin
        fl_raddr = sh_idx_q[IW-1:0];
        fl_we    = pend_q;
      end
      bffl_pkg::S_TOP: begin
        hd_we    = !top_fail;
        hd_waddr = top_q[HAW+2:3];
      end
      bffl_pkg::S_PUSH: begin
        fl_we         = 1'b1;
        fl_waddr      = count_q[IW-1:0];
        fl_wdata.addr = req_q.block_addr;
        fl_wdata.size = fr_ok ? hd_rdata : 17'd0;
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bffl_pkg::S_IDLE;
      heap_q      <= 17'h10000;
      top_q       <= 17'd8;
      count_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= (state_q == bffl_pkg::S_SCAN) ||
                 ((state_q == bffl_pkg::S_SHIFT) && sh_issue);
      if (cfg_we_i) begin
        heap_q  <= cfg_data_i;
        top_q   <= 17'd8;
        count_q <= '0;
      end else begin
        if (state_q == bffl_pkg::S_PUSH) begin
          count_q <= count_q + CW'(1);
        end
        if ((state_q == bffl_pkg::S_SHIFT) && !sh_issue && !pend_q) begin
          count_q <= cnt_m1;
        end
        if ((state_q == bffl_pkg::S_TOP) && !top_fail) begin
          top_q <= top_q + need_q[16:0];
        end
      end
      // Output register
      if ((state_q == bffl_pkg::S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q             <= in_data_i;
      need_q            <= need_in;
      scan_idx_q        <= cnt_m1[IW-1:0];
      res_q.status      <= bffl_pkg::ST_FULL;
      res_q.result_addr <= '0;
    end
    case (state_q)
      bffl_pkg::S_SCAN: begin
        pend_idx_q <= scan_idx_q;
        scan_idx_q <= scan_idx_q - IW'(1);
      end
      bffl_pkg::S_PICK: begin
        if (best_found) begin
          sh_idx_q          <= best_idx_p1;
          res_q.status      <= bffl_pkg::ST_REUSED;
          res_q.result_addr <= best_ent.addr;
        end
      end
      bffl_pkg::S_SHIFT: begin
        if (sh_issue) begin
          pend_idx_q <= sh_idx_q[IW-1:0];
          sh_idx_q   <= sh_idx_q + CW'(1);
        end
      end
      bffl_pkg::S_TOP: begin
        if (top_fail) begin
          res_q.status      <= bffl_pkg::ST_NOMEM;
          res_q.result_addr <= '0;
        end else begin
          res_q.status      <= bffl_pkg::ST_TOP;
          res_q.result_addr <= top_q[15:0] + bffl_pkg::HDR_BYTES;
        end
      end
      bffl_pkg::S_PUSH: begin
        res_q.status      <= bffl_pkg::ST_FREED;
        res_q.result_addr <= '0;
      end
      bffl_pkg::S_DONE: begin
        if (out_free) begin
          out_data_q <= res_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Free table: address and size per entry, ordered by age
  bffl_ram #(
    .W (bffl_pkg::ENTRY_W),
    .D (MAX_FREE)
  ) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fl_we),
    .waddr_i (fl_waddr),
    .wdata_i (fl_wdata),
    .raddr_i (fl_raddr),
    .rdata_o (fl_rdata)
  );

  // Block headers, one per 8-byte slot
  bffl_ram #(
    .W (17),
    .D (HDR_DEPTH)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (hd_we),
    .waddr_i (hd_waddr),
    .wdata_i (hd_wdata),
    .raddr_i (hd_raddr),
    .rdata_o (hd_rdata)
  );

  // Shared best-fit compare unit
  bffl_best #(
    .IW (IW)
  ) u_best (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (best_ctl),
    .idx_i   (pend_idx_q),
    .ent_i   (fl_rd_ent),
    .need_i  (need_q),
    .found_o (best_found),
    .idx_o   (best_idx),
    .ent_o   (best_ent)
  );

  // Free count never exceeds the table depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= MAX_FREE_V)
    else $error("free count above table depth");

  // Top stays 8-aligned and above the first header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (top_q[2:0] == 3'b000) && (top_q >= 17'd8))
    else $error("top offset misaligned");

  // Compaction writes stay inside the live part of the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bffl_pkg::S_SHIFT) && pend_q |-> (CW'(pend_idx_q) < count_q))
    else $error("compaction write outside table");

  // A new result is loaded only into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bffl_pkg::S_DONE) && out_valid_q && !out_ready_i |=>
    (state_q == bffl_pkg::S_DONE))
    else $error("result loaded over a waiting word");

endmodule

@@ rtl/core/bffl_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bffl_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                        wdata_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                        rdata_o
);

  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/bffl_best.sv @@
// Best-fit compare unit: keeps the smallest fitting entry seen in a scan.
module bffl_best #(
  parameter int IW = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  bffl_pkg::bffl_best_ctl_t ctl_i,
  input  logic [IW-1:0]           idx_i,
  input  bffl_pkg::bffl_entry_t   ent_i,
  input  logic [17:0]             need_i,
  output logic                    found_o,
  output logic [IW-1:0]           idx_o,
  output bffl_pkg::bffl_entry_t   ent_o
);

  logic                  found_q;
  logic [IW-1:0]         idx_q;
  bffl_pkg::bffl_entry_t ent_q;
  logic                  hit;

  // Fits the request and is strictly smaller than the best so far
  assign hit = ({1'b0, ent_i.size} >= need_i) && (!found_q || (ent_i.size < ent_q.size));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl_i.clr) begin
      found_q <= 1'b0;
    end else if (ctl_i.vld && hit) begin
      found_q <= 1'b1;
    end
  end

  // Winner payload
  always_ff @(posedge clk_i) begin
    if (!ctl_i.clr && ctl_i.vld && hit) begin
      idx_q <= idx_i;
      ent_q <= ent_i;
    end
  end

  assign found_o = found_q;
  assign idx_o   = idx_q;
  assign ent_o   = ent_q;

endmodule

@@ tb/best_fit_free_list_allocator_core_tb.sv @@
// Self-checking testbench for the best-fit free-list allocator core.
`timescale 1ns / 1ps

module best_fit_free_list_allocator_core_tb;

  localparam int NUM_FREE   = 16;
  localparam int HEAP_MAX   = 65536;
  localparam int SLOTS      = HEAP_MAX / 8;
  localparam int HDR_B      = bffl_pkg::HDR_BYTES;
  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 400;
  localparam int MAX_SHOW   = 10;

  // Receiver stall patterns
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BLOCK
  } rx_mode_e;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  bffl_pkg::bffl_req_t in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  bffl_pkg::bffl_rsp_t out_data;
  logic                cfg_we    = 1'b0;
  logic [16:0]         cfg_data  = '0;

  // Allocator state as the testbench sees it
  int heap_reg = 65536;
  int top_off  = 8;
  int fb_addr [NUM_FREE];
  int fb_size [NUM_FREE];
  int fb_count = 0;
  int hdr_mem [SLOTS];
  bit hdr_valid [SLOTS];
  int hdr_list [$];

  // Expected result words, oldest first
  bffl_pkg::bffl_rsp_t expect_q [$];
  int                  live_q [$];

  int       err_cnt     = 0;
  int       n_words     = 0;
  int       n_cfg       = 0;
  int       stat_seen [5];
  int       burst_left  = 0;
  int       idle_cycles = 0;
  bit       hold_pending = 1'b0;
  int       hold_left   = 0;
  int       seg_left    = 0;
  rx_mode_e seg_mode    = RX_OPEN;
  bffl_pkg::bffl_rsp_t want_rsp;

  best_fit_free_list_allocator_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Header store write, remembering which slots hold a real size
  function automatic void set_header(int slot, int sz);
    hdr_mem[slot] = sz;
    if (!hdr_valid[slot]) begin
      hdr_valid[slot] = 1'b1;
      hdr_list.push_back(slot);
    end
  endfunction

  // One command applied to the allocator state; returns the result word
  function automatic bffl_pkg::bffl_rsp_t heap_step(bffl_pkg::bffl_req_t w);
    bffl_pkg::bffl_rsp_t r;
    int                  need, lim, pick, k, a, sz;
    bit                  found;
    r.status      = bffl_pkg::ST_NOMEM;
    r.result_addr = '0;
    if (w.cmd == bffl_pkg::CMD_ALLOC) begin
      need  = ((int'(w.request_size) + 7) / 8) * 8 + HDR_B;
      found = 1'b0;
      pick  = 0;
      // newest first; an equal size further back never displaces the pick
      for (k = fb_count - 1; k >= 0; k--) begin
        if (fb_size[k] >= need && (!found || fb_size[k] < fb_size[pick])) begin
          found = 1'b1;
          pick  = k;
        end
      end
      if (found) begin
        a = fb_addr[pick];
        set_header(((a - HDR_B) & 'hFFFF) >> 3, need);
        for (k = pick; k + 1 < fb_count; k++) begin
          fb_addr[k] = fb_addr[k + 1];
          fb_size[k] = fb_size[k + 1];
        end
        fb_count--;
        r.status      = bffl_pkg::ST_REUSED;
        r.result_addr = a[15:0];
      end else begin
        lim = (heap_reg > HEAP_MAX) ? HEAP_MAX : heap_reg;
        if (need <= lim && lim - need >= top_off && top_off + HDR_B <= 'hFFFF) begin
          set_header(top_off >> 3, need);
          r.status      = bffl_pkg::ST_TOP;
          r.result_addr = 16'(top_off + HDR_B);
          top_off      += need;
        end
      end
    end else if (fb_count >= NUM_FREE) begin
      r.status = bffl_pkg::ST_FULL;
    end else begin
      // low address bits do not matter for the header lookup
      a  = int'(w.block_addr);
      sz = 0;
      if (a >= HDR_B) sz = hdr_mem[(a - HDR_B) >> 3];
      fb_addr[fb_count] = a;
      fb_size[fb_count] = sz;
      fb_count++;
      r.status = bffl_pkg::ST_FREED;
    end
    return r;
  endfunction

  // Send one word, record its expected result, then maybe pause
  task automatic send_word(input bffl_pkg::bffl_req_t w, output bffl_pkg::bffl_rsp_t rsp);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rsp = heap_step(w);
    expect_q.push_back(rsp);
    n_words++;
    stat_seen[rsp.status]++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic send_alloc(input int blk_bytes, output bffl_pkg::bffl_rsp_t rsp);
    bffl_pkg::bffl_req_t w;
    w.cmd          = bffl_pkg::CMD_ALLOC;
    w.request_size = 17'(blk_bytes);
    w.block_addr   = 16'($urandom);
    send_word(w, rsp);
    if (rsp.status == bffl_pkg::ST_TOP || rsp.status == bffl_pkg::ST_REUSED)
      live_q.push_back(rsp.result_addr);
  endtask

  task automatic send_free(input int addr, output bffl_pkg::bffl_rsp_t rsp);
    bffl_pkg::bffl_req_t w;
    w.cmd          = bffl_pkg::CMD_FREE;
    w.request_size = 17'($urandom);
    w.block_addr   = 16'(addr);
    send_word(w, rsp);
  endtask

  // Stop offering words and wait for every expected result
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expect_q.size() != 0) @(posedge clk);
  endtask

  // Heap size write; only done with the block idle
  task automatic write_heap_size(input int value);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= 17'(value);
    @(posedge clk);
    cfg_we   <= 1'b0;
    heap_reg = value & 'h1FFFF;
    top_off  = 8;
    fb_count = 0;
    live_q.delete();
    n_cfg++;
  endtask

  // Header-only blocks, rounding, best fit, ties, odd free addresses
  task automatic test_basic_ops();
    bffl_pkg::bffl_rsp_t blk_a, blk_b, blk_c, big, rsp;
    send_alloc(0, blk_a);
    send_alloc(1, blk_b);
    send_alloc(8, blk_c);
    send_alloc(65536, rsp);                       // larger than the heap
    send_free(blk_a.result_addr, rsp);
    send_free(blk_c.result_addr | 16'd3, rsp);    // unaligned free
    send_free(3, rsp);                            // below the heap base, size 0
    send_alloc(0, rsp);                           // exact fit
    send_free(blk_b.result_addr, rsp);
    send_alloc(5, rsp);                           // equal sizes: newest wins
    send_free(blk_b.result_addr, rsp);            // double free
    send_alloc(40000, big);
    send_alloc(100, big);                         // payload above 32K
    send_free(big.result_addr, rsp);
  endtask

  // Fill the free table, overflow it, then scan a full table
  task automatic test_table_full();
    bffl_pkg::bffl_rsp_t blk, rsp;
    send_alloc(24, blk);
    while (fb_count < NUM_FREE) send_free(blk.result_addr, rsp);
    send_free(blk.result_addr, rsp);              // dropped
    send_alloc(24, rsp);
    send_alloc(65535, rsp);
  endtask

  // Smallest heap and an oversized setting that clamps
  task automatic test_heap_limits();
    bffl_pkg::bffl_rsp_t rsp;
    write_heap_size(16);
    send_alloc(0, rsp);
    send_alloc(0, rsp);                           // heap used up
    write_heap_size('h1FFFF);
    send_alloc(65512, rsp);                       // top ends just below 64K
    send_alloc(0, rsp);                           // payload would pass 16 bits
  endtask

  // Mixed traffic over several heap sizes, mostly well-formed
  task automatic test_random_traffic();
    int                  heap_set [6];
    int                  p, n, pick, idx, a;
    bffl_pkg::bffl_rsp_t rsp;
    heap_set = '{65536, 4096, 200, 131071, 1024, 65536};
    for (p = 0; p < 6; p++) begin
      write_heap_size(heap_set[p]);
      for (n = 0; n < 135; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50 || pick >= 95 || (pick < 85 && live_q.size() == 0)) begin
          idx = $urandom_range(0, 99);
          if (idx < 70)      a = $urandom_range(0, 64);
          else if (idx < 90) a = $urandom_range(65, 1024);
          else if (idx < 98) a = $urandom_range(0, 8192);
          else               a = $urandom_range(0, 65536);
          send_alloc(a, rsp);
        end else if (pick < 85) begin
          idx = $urandom_range(0, live_q.size() - 1);
          a   = live_q[idx];
          live_q.delete(idx);
          if ($urandom_range(0, 9) == 0) a = (a & 'hFFF8) | $urandom_range(0, 7);
          send_free(a, rsp);
        end else if (pick < 92 && hdr_list.size() != 0) begin
          // any slot with a written header, possibly freed twice
          a = hdr_list[$urandom_range(0, hdr_list.size() - 1)] * 8 + HDR_B;
          send_free(a | $urandom_range(0, 7), rsp);
        end else begin
          send_free($urandom_range(0, 7), rsp);
        end
      end
    end
  endtask

  // Receiver holds off for a long stretch while words keep coming
  task automatic test_output_stall();
    bffl_pkg::bffl_rsp_t rsp;
    int                  k;
    write_heap_size(65536);
    hold_pending = 1'b1;
    for (k = 0; k < 12; k++) begin
      send_alloc($urandom_range(0, 64), rsp);
      if (live_q.size() != 0) send_free(live_q.pop_front(), rsp);
      else send_free(3, rsp);
    end
  endtask

  // Output-side stall pattern, with an occasional long hold
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_pending) begin
        hold_left    = LONG_HOLD;
        hold_pending = 1'b0;
      end
      if (seg_left == 0) begin
        seg_mode = rx_mode_e'($urandom_range(0, 3));
        seg_left = $urandom_range(8, 64);
      end
      seg_left--;
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (seg_mode)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= (seg_left < 4);
        endcase
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expect_q.size() == 0) begin
        if (err_cnt < MAX_SHOW)
          $display("unexpected result word: status %0d addr 0x%04h",
                   out_data.status, out_data.result_addr);
        err_cnt++;
      end else begin
        want_rsp = expect_q.pop_front();
        if (out_data.status !== want_rsp.status ||
            out_data.result_addr !== want_rsp.result_addr) begin
          if (err_cnt < MAX_SHOW)
            $display("mismatch: expected status %0d addr 0x%04h, got status %0d addr 0x%04h",
                     want_rsp.status, want_rsp.result_addr,
                     out_data.status, out_data.result_addr);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_table_full();
    test_heap_limits();
    test_random_traffic();
    test_output_stall();
    drain_results();
    repeat (2 * NUM_FREE + 8) @(posedge clk);
    $display("covered %0d words: %0d from top, %0d reused, %0d out of memory",
             n_words, stat_seen[bffl_pkg::ST_TOP], stat_seen[bffl_pkg::ST_REUSED],
             stat_seen[bffl_pkg::ST_NOMEM]);
    $display("  %0d freed, %0d dropped on a full table, %0d heap size writes",
             stat_seen[bffl_pkg::ST_FREED], stat_seen[bffl_pkg::ST_FULL], n_cfg);
    if (err_cnt == 0 && expect_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ best_fit_free_list_allocator_core.f @@
rtl/core/bffl_pkg.sv
rtl/core/bffl_ram.sv
rtl/core/bffl_best.sv
rtl/core/best_fit_free_list_allocator_core.sv
tb/best_fit_free_list_allocator_core_tb.sv
